// ----- src/nir_pkg.sv -----
// Shared types, constants and helpers for the NEC IR edge decoder.
// No dependencies.
package nir_pkg;

    localparam int FRAME_BITS = 32;
    localparam int NUM_REGS   = 6;
    localparam int REG_W      = 32;
    localparam int IDX_W      = 3;
    localparam int TIME_W     = 16;
    localparam int BITS_W     = 6;

    localparam logic [BITS_W-1:0] BITS_INIT = BITS_W'(FRAME_BITS & 63);

    localparam logic [IDX_W-1:0] REG_PRO_GAP   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PRO_PULSE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_REP_PULSE = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SYM_GAP   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_ZERO      = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_ONE       = IDX_W'(5);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_INIT,
        PH_GAP,
        PH_PULSE
    } phase_t;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] win_array_t;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   last_time;
        logic                have_last;
        logic [REG_W-1:0]    shift_code;
        logic [BITS_W-1:0]   bits_left;
        logic                repeat_seen;
        logic                skip_next;
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [REG_W-1:0] code;
        logic             is_repeat;
    } result_t;

    // inclusive window: min in bits 15:0, max in bits 31:16
    function automatic logic in_window(input logic [TIME_W-1:0] interval,
                                       input logic [REG_W-1:0] window);
        in_window = (interval >= window[15:0]) && (interval <= window[31:16]);
    endfunction

endpackage

// ----- src/nir_step.sv -----
// Next-state and result logic for one edge item.
// Depends on nir_pkg.
module nir_step
(
    input  nir_pkg::state_t              cur,
    input  logic [nir_pkg::TIME_W-1:0]   edge_time,
    input  logic                         first_edge,
    input  nir_pkg::win_array_t          win,
    output nir_pkg::state_t              nxt,
    output nir_pkg::result_t             res
);

    logic [nir_pkg::TIME_W-1:0] interval;
    logic                       hit_pro_gap;
    logic                       hit_pro_pulse;
    logic                       hit_rep_pulse;
    logic                       hit_sym_gap;
    logic                       hit_zero;
    logic                       hit_one;
    logic [nir_pkg::BITS_W-1:0] bits_dec;

    assign interval      = edge_time - cur.last_time;
    assign hit_pro_gap   = nir_pkg::in_window(interval, win[nir_pkg::REG_PRO_GAP]);
    assign hit_pro_pulse = nir_pkg::in_window(interval, win[nir_pkg::REG_PRO_PULSE]);
    assign hit_rep_pulse = nir_pkg::in_window(interval, win[nir_pkg::REG_REP_PULSE]);
    assign hit_sym_gap   = nir_pkg::in_window(interval, win[nir_pkg::REG_SYM_GAP]);
    assign hit_zero      = nir_pkg::in_window(interval, win[nir_pkg::REG_ZERO]);
    assign hit_one       = nir_pkg::in_window(interval, win[nir_pkg::REG_ONE]);
    assign bits_dec      = cur.bits_left - nir_pkg::BITS_W'(1);

    always_comb
    begin
        nxt           = cur;
        res.valid     = 1'b0;
        res.code      = '0;
        res.is_repeat = 1'b0;

        if (first_edge || !cur.have_last)
        begin
            nxt.last_time   = edge_time;
            nxt.have_last   = 1'b1;
            nxt.phase       = nir_pkg::PH_IDLE;
            nxt.shift_code  = '0;
            nxt.bits_left   = '0;
            nxt.repeat_seen = 1'b0;
            nxt.skip_next   = 1'b0;
        end
        else
        begin
            nxt.last_time = edge_time;
            if (cur.skip_next)
            begin
                nxt.skip_next = 1'b0;
            end
            else
            begin
                case (cur.phase)
                    nir_pkg::PH_IDLE, nir_pkg::PH_GAP:
                    begin
                        if (cur.phase == nir_pkg::PH_GAP &&
                            cur.bits_left != '0 && hit_sym_gap)
                        begin
                            nxt.phase = nir_pkg::PH_PULSE;
                        end
                        else if (hit_pro_gap)
                        begin
                            nxt.phase      = nir_pkg::PH_INIT;
                            nxt.shift_code = '0;
                        end
                        else
                        begin
                            nxt.phase     = nir_pkg::PH_IDLE;
                            nxt.skip_next = 1'b1;
                        end
                    end
                    nir_pkg::PH_INIT:
                    begin
                        if (hit_rep_pulse)
                        begin
                            nxt.repeat_seen = 1'b1;
                            nxt.bits_left   = '0;
                            nxt.phase       = nir_pkg::PH_IDLE;
                            res.valid       = 1'b1;
                            res.is_repeat   = 1'b1;
                        end
                        else if (hit_pro_pulse)
                        begin
                            nxt.repeat_seen = 1'b0;
                            nxt.bits_left   = nir_pkg::BITS_INIT;
                            nxt.phase       = nir_pkg::PH_GAP;
                        end
                        else
                        begin
                            nxt.phase = nir_pkg::PH_IDLE;
                        end
                    end
                    nir_pkg::PH_PULSE:
                    begin
                        if (hit_zero || hit_one)
                        begin
                            nxt.shift_code = {cur.shift_code[nir_pkg::REG_W-2:0], !hit_zero};
                            nxt.bits_left  = bits_dec;
                            if (bits_dec == '0)
                            begin
                                nxt.phase     = nir_pkg::PH_IDLE;
                                res.valid     = 1'b1;
                                res.code      = {cur.shift_code[nir_pkg::REG_W-2:0], !hit_zero};
                                res.is_repeat = cur.repeat_seen;
                            end
                            else
                            begin
                                nxt.phase = nir_pkg::PH_GAP;
                            end
                        end
                        else
                        begin
                            nxt.phase = nir_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        nxt.phase = nir_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ----- src/nec_ir_edge_decoder_unit.sv -----
// An accepted item waits in the input register, is processed when not stalled, and its result is registered.
// Throughput: one item per cycle while no stalled held result blocks processing.
// in_stall rises only when a held result blocks an item that is waiting to be processed.
// Reset (async, rst_n low): parser idle, no previous edge, shift code cleared, windows zero; code output not reset.
// Top level of the NEC IR edge decoder; depends on nir_pkg and nir_step.
module nec_ir_edge_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nir_pkg::IDX_W-1:0]         cfg_index,
    input  logic [nir_pkg::REG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [nir_pkg::TIME_W-1:0]        edge_time,
    input  logic                              first_edge,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nir_pkg::REG_W-1:0]         code,
    output logic                              is_repeat
);

    nir_pkg::win_array_t         win_reg;
    logic                        in_valid_reg;
    logic [nir_pkg::TIME_W-1:0]  edge_time_reg;
    logic                        first_edge_reg;
    nir_pkg::state_t             state_reg;
    nir_pkg::state_t             state_next;
    nir_pkg::result_t            res;
    logic                        out_valid_reg;
    logic [nir_pkg::REG_W-1:0]   code_reg;
    logic                        is_repeat_reg;
    logic                        process;
    logic                        in_take;

    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign in_take  = in_valid && !in_stall;

    nir_step u_step
    (
        .cur        (state_reg),
        .edge_time  (edge_time_reg),
        .first_edge (first_edge_reg),
        .win        (win_reg),
        .nxt        (state_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg_we && cfg_index < nir_pkg::IDX_W'(nir_pkg::NUM_REGS))
        begin
            win_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end
            if (process)
            begin
                state_reg <= state_next;
            end
            if (process && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            edge_time_reg  <= edge_time;
            first_edge_reg <= first_edge;
        end
        if (process && res.valid)
        begin
            code_reg      <= res.code;
            is_repeat_reg <= res.is_repeat;
        end
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign is_repeat = is_repeat_reg;

`ifndef SYNTHESIS
    a_gap_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == nir_pkg::PH_GAP || state_reg.phase == nir_pkg::PH_PULSE)
        |-> state_reg.bits_left != '0)
        else $error("symbol phase with no bits left");
    a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.skip_next |-> state_reg.phase == nir_pkg::PH_IDLE)
        else $error("skip pending outside idle");
    a_repeat_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_repeat) |-> code == '0)
        else $error("repetition with non-zero code");
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with nothing held");
`endif

endmodule

// ----- tb/nec_ir_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the NEC IR edge decoder: watches the config port and both item channels,
// predicts decoded frames and repeats, and compares each result item. Depends on nir_pkg.
module nec_ir_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [nir_pkg::IDX_W-1:0]    cfg_index,
    input  logic [nir_pkg::REG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [nir_pkg::TIME_W-1:0]   edge_time,
    input  logic                         first_edge,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [nir_pkg::REG_W-1:0]    code,
    input  logic                         is_repeat,
    output int                           mismatches,
    output int                           pending
);

    typedef struct packed {
        logic [nir_pkg::REG_W-1:0] code;
        logic                      is_repeat;
    } frame_t;

    logic [nir_pkg::REG_W-1:0]  win [nir_pkg::NUM_REGS];
    nir_pkg::phase_t            ph;
    logic [nir_pkg::TIME_W-1:0] prev_t;
    logic                       have_prev;
    logic [nir_pkg::REG_W-1:0]  sr;
    logic [nir_pkg::BITS_W-1:0] left;
    logic                       rep_flag;
    logic                       skip;
    frame_t                     frames_due [$];

    function automatic logic fits(input logic [nir_pkg::TIME_W-1:0] d,
                                  input logic [nir_pkg::REG_W-1:0] w);
        return (d >= w[15:0]) && (d <= w[31:16]);
    endfunction

    task automatic idle_gap(input logic [nir_pkg::TIME_W-1:0] d);
        if (fits(d, win[nir_pkg::REG_PRO_GAP]))
        begin
            ph = nir_pkg::PH_INIT;
            sr = '0;
        end
        else
        begin
            ph   = nir_pkg::PH_IDLE;
            skip = 1'b1;
        end
    endtask

    task automatic decode_edge(input logic [nir_pkg::TIME_W-1:0] t, input logic first);
        logic [nir_pkg::TIME_W-1:0] d;
        logic                       b;
        frame_t                     f;
        if (first || !have_prev)
        begin
            prev_t    = t;
            have_prev = 1'b1;
            ph        = nir_pkg::PH_IDLE;
            sr        = '0;
            left      = '0;
            rep_flag  = 1'b0;
            skip      = 1'b0;
            return;
        end
        d      = t - prev_t;
        prev_t = t;
        if (skip)
        begin
            skip = 1'b0;
            return;
        end
        case (ph)
            nir_pkg::PH_IDLE:
                idle_gap(d);
            nir_pkg::PH_INIT:
                if (fits(d, win[nir_pkg::REG_REP_PULSE]))
                begin
                    rep_flag    = 1'b1;
                    left        = '0;
                    ph          = nir_pkg::PH_IDLE;
                    f.code      = '0;
                    f.is_repeat = 1'b1;
                    frames_due.push_back(f);
                end
                else if (fits(d, win[nir_pkg::REG_PRO_PULSE]))
                begin
                    rep_flag = 1'b0;
                    left     = nir_pkg::BITS_INIT;
                    ph       = nir_pkg::PH_GAP;
                end
                else
                    ph = nir_pkg::PH_IDLE;
            nir_pkg::PH_GAP:
                if (left != 0 && fits(d, win[nir_pkg::REG_SYM_GAP]))
                    ph = nir_pkg::PH_PULSE;
                else
                    idle_gap(d);
            default:
            begin
                if (fits(d, win[nir_pkg::REG_ZERO]))
                    b = 1'b0;
                else if (fits(d, win[nir_pkg::REG_ONE]))
                    b = 1'b1;
                else
                begin
                    ph = nir_pkg::PH_IDLE;
                    return;
                end
                sr   = {sr[nir_pkg::REG_W-2:0], b};
                left = left - 1'b1;
                if (left == 0)
                begin
                    ph          = nir_pkg::PH_IDLE;
                    f.code      = sr;
                    f.is_repeat = rep_flag;
                    frames_due.push_back(f);
                end
                else
                    ph = nir_pkg::PH_GAP;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_t f;
        if (!rst_n)
        begin
            for (int i = 0; i < nir_pkg::NUM_REGS; i++)
                win[i] = '0;
            ph         = nir_pkg::PH_IDLE;
            prev_t     = '0;
            have_prev  = 1'b0;
            sr         = '0;
            left       = '0;
            rep_flag   = 1'b0;
            skip       = 1'b0;
            mismatches = 0;
            pending    = 0;
            frames_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected result item: code %h is_repeat %b",
                             $time, code, is_repeat);
                    mismatches++;
                end
                else
                begin
                    f = frames_due.pop_front();
                    if (code !== f.code)
                    begin
                        $display("%0t: code expected %h got %h", $time, f.code, code);
                        mismatches++;
                    end
                    if (is_repeat !== f.is_repeat)
                    begin
                        $display("%0t: is_repeat expected %b got %b",
                                 $time, f.is_repeat, is_repeat);
                        mismatches++;
                    end
                end
            end
            if (cfg_we && cfg_index < nir_pkg::NUM_REGS)
                win[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                decode_edge(edge_time, first_edge);
            pending = frames_due.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the NEC IR edge decoder bench: clock, reset, window setup and edge stimulus.
// Depends on nir_pkg, nec_ir_edge_decoder_unit and nec_ir_checker.
module tb;

    localparam int ITEMS       = 1100;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 60;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [nir_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [nir_pkg::REG_W-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [nir_pkg::TIME_W-1:0] edge_time = '0;
    logic                       first_edge = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [nir_pkg::REG_W-1:0]  code;
    logic                       is_repeat;
    int                         mismatches;
    int                         pending;

    logic [nir_pkg::REG_W-1:0]  win [nir_pkg::NUM_REGS];
    logic [nir_pkg::TIME_W-1:0] now_t = '0;
    int                         n_items = 0;
    int                         snd_idle = 0;
    int                         rcv_idle = 0;
    int                         holds_asked = 0;
    int                         holds_given = 0;
    int                         quiet = 0;

    nec_ir_edge_decoder_unit DUT (.*);
    nec_ir_checker CHK (.*);

    always #5 clk = ~clk;

    function automatic logic [nir_pkg::REG_W-1:0] span(input int lo, input int hi);
        return {nir_pkg::TIME_W'(hi), nir_pkg::TIME_W'(lo)};
    endfunction

    function automatic logic [nir_pkg::TIME_W-1:0] pick_in(input logic [nir_pkg::REG_W-1:0] w);
        if (w[15:0] <= w[31:16])
            return nir_pkg::TIME_W'($urandom_range(int'(w[31:16]), int'(w[15:0])));
        return nir_pkg::TIME_W'($urandom);
    endfunction

    function automatic logic [nir_pkg::REG_W-1:0] pick_code();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_edge(input logic [nir_pkg::TIME_W-1:0] t, input logic first);
        if (n_items < ITEMS / 3)
        begin
            snd_idle = 28;
            rcv_idle = 69;
        end
        else if (n_items < 2 * ITEMS / 3)
        begin
            snd_idle = 69;
            rcv_idle = 28;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        edge_time  <= t;
        first_edge <= first;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        n_items++;
    endtask

    task automatic step(input logic [nir_pkg::TIME_W-1:0] d);
        now_t = now_t + d;
        send_edge(now_t, 1'b0);
    endtask

    task automatic capture(input logic [nir_pkg::TIME_W-1:0] t);
        now_t = t;
        send_edge(t, 1'b1);
    endtask

    task automatic send_repeat();
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_REP_PULSE]));
    endtask

    // cut < 0 gives a whole frame; otherwise noise replaces the symbol gap of bit cut
    task automatic send_command(input logic [nir_pkg::REG_W-1:0] bits, input int cut);
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_PRO_PULSE]));
        for (int k = nir_pkg::FRAME_BITS - 1; k >= 0; k--)
        begin
            if (k == cut)
            begin
                step(nir_pkg::TIME_W'($urandom));
                return;
            end
            step(pick_in(win[nir_pkg::REG_SYM_GAP]));
            step(pick_in(bits[k] ? win[nir_pkg::REG_ONE] : win[nir_pkg::REG_ZERO]));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [nir_pkg::IDX_W-1:0] idx,
                             input logic [nir_pkg::REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        win[idx]   = val;
        @(negedge clk);
    endtask

    task automatic load_windows(input logic [nir_pkg::REG_W-1:0] w0,
                                input logic [nir_pkg::REG_W-1:0] w1,
                                input logic [nir_pkg::REG_W-1:0] w2,
                                input logic [nir_pkg::REG_W-1:0] w3,
                                input logic [nir_pkg::REG_W-1:0] w4,
                                input logic [nir_pkg::REG_W-1:0] w5);
        wait_drained();
        write_reg(nir_pkg::REG_PRO_GAP, w0);
        write_reg(nir_pkg::REG_PRO_PULSE, w1);
        write_reg(nir_pkg::REG_REP_PULSE, w2);
        write_reg(nir_pkg::REG_SYM_GAP, w3);
        write_reg(nir_pkg::REG_ZERO, w4);
        write_reg(nir_pkg::REG_ONE, w5);
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int upto);
        int r;
        while (n_items < upto)
        begin
            r = $urandom_range(99);
            if (r < 40)
                send_command(pick_code(),
                             ($urandom_range(9) == 0) ?
                                 int'($urandom_range(nir_pkg::FRAME_BITS - 1)) : -1);
            else if (r < 70)
                send_repeat();
            else if (r < 85)
                step(nir_pkg::TIME_W'($urandom));
            else if (r < 92)
                capture(nir_pkg::TIME_W'($urandom));
            else
            begin
                step(pick_in(win[nir_pkg::REG_PRO_GAP]));
                step(nir_pkg::TIME_W'($urandom));
            end
        end
    endtask

    // result side: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holds_given != holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_given++;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("FAIL nec_ir_edge_decoder_unit");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disjoint windows, but for the symbol gap and zero windows, which are the same
        load_windows(span(850, 950), span(400, 500), span(200, 250),
                     span(50, 62), span(50, 62), span(150, 180));

        // first item without a previous edge, then a repeat across the time wrap
        now_t = 16'hFFF0;
        send_edge(now_t, 1'b0);
        step(win[nir_pkg::REG_PRO_GAP][31:16]);
        step(win[nir_pkg::REG_REP_PULSE][15:0]);
        // idle noise skips the following interval
        step(16'hFFFF);
        step(16'h0000);
        step(win[nir_pkg::REG_PRO_GAP][15:0]);
        step(win[nir_pkg::REG_REP_PULSE][31:16]);
        // init noise
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(16'hFFFF);
        // noisy symbol gap taken again as a prologue gap
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_PRO_PULSE]));
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_REP_PULSE]));
        // pulse noise
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_PRO_PULSE]));
        step(pick_in(win[nir_pkg::REG_SYM_GAP]));
        step(16'd1000);
        // new capture mid-frame
        step(pick_in(win[nir_pkg::REG_PRO_GAP]));
        step(pick_in(win[nir_pkg::REG_PRO_PULSE]));
        capture(16'h0000);
        send_repeat();
        capture(16'hFFFF);

        // back-pressure: the input stalls while the receiver holds off a result
        holds_asked++;
        repeat (10) send_repeat();
        wait_drained();

        random_traffic(ITEMS / 4);

        // overlapping windows
        load_windows(span(800, 1000), span(300, 600), span(250, 400),
                     span(40, 900), span(40, 120), span(100, 200));
        random_traffic(ITEMS / 2);

        // extremes: full range, single points at either end
        load_windows(32'hFFFF0000, 32'hFFFFFFFF, 32'h00000000,
                     32'hFFFF0000, 32'h00000000, 32'hFFFFFFFF);
        random_traffic(3 * ITEMS / 4);

        // repetition window empty (min above max)
        load_windows(span(1000, 1200), span(500, 600), 32'h0000FFFF,
                     span(40, 80), span(40, 80), span(100, 160));
        random_traffic(ITEMS);

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("PASS nec_ir_edge_decoder_unit");
        else
            $display("FAIL nec_ir_edge_decoder_unit");
        $finish;
    end

endmodule

// ----- sim.f -----
src/nir_pkg.sv
src/nir_step.sv
src/nec_ir_edge_decoder_unit.sv
tb/nec_ir_checker.sv
tb/tb.sv
